// ===== hw/rtl/pbd_pkg.sv =====
// shared types, widths and command codes for the panel button and dial decoder
package pbd_pkg;

  localparam int BUTTON_COUNT = 6;
  localparam int RUN_WIDTH    = 16;
  localparam int HOLD_WIDTH   = 16;
  localparam int LEVEL_WIDTH  = 6;
  localparam int CMD_WIDTH    = 4;
  localparam int ADDR_WIDTH   = 3;
  localparam int DATA_WIDTH   = 32;
  localparam int CMP_WIDTH    = (RUN_WIDTH > HOLD_WIDTH) ? RUN_WIDTH : HOLD_WIDTH;

  typedef logic [RUN_WIDTH-1:0]   run_t;
  typedef logic [HOLD_WIDTH-1:0]  hold_t;
  typedef logic [CMD_WIDTH-1:0]   cmd_t;
  typedef logic signed [2:0]      phase_t;
  typedef logic signed [1:0]      dir_t;

  // command codes
  localparam cmd_t CMD_NONE  = cmd_t'(0);
  localparam cmd_t CMD_LEFT  = cmd_t'(BUTTON_COUNT + 1);
  localparam cmd_t CMD_RIGHT = cmd_t'(BUTTON_COUNT + 2);

  // register indexes
  localparam logic REG_BUTTON_HOLD = 1'b0;
  localparam logic REG_DIAL_HOLD   = 1'b1;

  localparam hold_t HOLD_RESET = hold_t'(50);

  // dial phase and direction codes
  localparam phase_t PH_ZERO = 3'sd0;
  localparam phase_t PH_POS1 = 3'sd1;
  localparam phase_t PH_POS2 = 3'sd2;
  localparam phase_t PH_NEG1 = -3'sd1;
  localparam phase_t PH_NEG2 = -3'sd2;

  localparam dir_t DIR_NONE  = 2'sd0;
  localparam dir_t DIR_RIGHT = 2'sd1;
  localparam dir_t DIR_LEFT  = -2'sd1;

  typedef struct packed {
    logic active;
    logic done;
    dir_t direction;
  } dial_status_t;

endpackage

// ===== hw/rtl/pbd_run_counter.sv =====
// saturating low-run counter for one active-low line
module pbd_run_counter (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           level,
  input  pbd_pkg::hold_t hold_ticks,
  output logic           pressed
);
  import pbd_pkg::*;

  run_t                 run_r;
  run_t                 run_nxt;
  logic [CMP_WIDTH-1:0] run_ext;
  logic [CMP_WIDTH-1:0] run_nxt_ext;
  logic [CMP_WIDTH-1:0] hold_ext;

  assign run_ext     = CMP_WIDTH'(run_r);
  assign run_nxt_ext = CMP_WIDTH'(run_nxt);
  assign hold_ext    = CMP_WIDTH'(hold_ticks);

  always_comb begin
    run_nxt = run_r;
    if (level) begin
      run_nxt = '0;
    end else if ((run_ext < hold_ext) && (run_r != {RUN_WIDTH{1'b1}})) begin
      run_nxt = run_r + run_t'(1);
    end
  end

  assign pressed = (run_nxt_ext >= hold_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (en) begin
      run_r <= run_nxt;
    end
  end

endmodule

// ===== hw/rtl/pbd_dial_tracker.sv =====
// dial phase tracker: follows the quadrature phase and reports a finished turn
module pbd_dial_tracker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  pa,
  input  logic                  pb,
  output pbd_pkg::dial_status_t status
);
  import pbd_pkg::*;

  phase_t phase_r, phase_nxt;
  dir_t   dir_r, dir_nxt;
  logic   active_r, active_nxt;
  logic   done;

  always_comb begin
    phase_nxt  = phase_r;
    dir_nxt    = dir_r;
    active_nxt = active_r;
    done       = 1'b0;
    // turn start clears phase and direction
    if (!active_nxt && (pa || pb)) begin
      active_nxt = 1'b1;
      phase_nxt  = PH_ZERO;
      dir_nxt    = DIR_NONE;
    end
    if (active_nxt) begin
      if ((phase_nxt == PH_POS2) && !pa) dir_nxt = DIR_RIGHT;
      if ((phase_nxt == PH_NEG2) && !pb) dir_nxt = DIR_LEFT;
      if (pa && !pb) phase_nxt = PH_POS1;
      if (!pa && pb) phase_nxt = PH_NEG1;
      if ((phase_nxt == PH_POS1) && pb) phase_nxt = PH_POS2;
      if ((phase_nxt == PH_NEG1) && pa) phase_nxt = PH_NEG2;
      if (!pa && !pb) begin
        active_nxt = 1'b0;
        done       = 1'b1;
      end
    end
  end

  assign status.active    = active_nxt;
  assign status.done      = done;
  assign status.direction = dir_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_ZERO;
      dir_r    <= DIR_NONE;
      active_r <= 1'b0;
    end else if (en) begin
      phase_r  <= phase_nxt;
      dir_r    <= dir_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// ===== hw/rtl/panel_button_and_dial_decoder_top.sv =====
// top level of the panel button and dial decoder
// Each input word is one tick's sample of six active-low buttons and two
// active-low dial lines; every word gives exactly one output word holding a
// command code (zero when nothing new happened). A word is registered on
// entry, then the run counters, the dial phase tracker and the command
// selection update together as the word moves into the output register.
// One word is taken per clock when the output side does not stall; a word
// goes through the input register, then the output register. The output
// register frees the input side, so a new word enters while a finished word
// still waits. The user must write hold thresholds over the register port
// only while idle; the block itself does not enforce it.
module panel_button_and_dial_decoder_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pbd_pkg::LEVEL_WIDTH-1:0]  in_button_levels,
  input  logic                             in_dial_a_level,
  input  logic                             in_dial_b_level,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pbd_pkg::CMD_WIDTH-1:0]    out_command,
  // register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pbd_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [pbd_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic [pbd_pkg::DATA_WIDTH-1:0]   prdata,
  output logic                             pready
);
  import pbd_pkg::*;

  // configuration registers
  hold_t button_hold_r;
  hold_t dial_hold_r;
  logic  cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_hold_r <= HOLD_RESET;
      dial_hold_r   <= HOLD_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_BUTTON_HOLD: button_hold_r <= pwdata[HOLD_WIDTH-1:0];
        REG_DIAL_HOLD:   dial_hold_r   <= pwdata[HOLD_WIDTH-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BUTTON_HOLD: prdata = DATA_WIDTH'(button_hold_r);
      REG_DIAL_HOLD:   prdata = DATA_WIDTH'(dial_hold_r);
      default:         prdata = '0;
    endcase
  end

  // input register
  logic                   s1_valid_r;
  logic [LEVEL_WIDTH-1:0] s1_buttons_r;
  logic                   s1_dial_a_r;
  logic                   s1_dial_b_r;
  logic                   s1_move;
  logic                   in_take;

  // output register
  logic out_valid_r;
  cmd_t out_command_r;
  cmd_t last_cmd_r;

  // the stage-one word moves on when the output register is empty or draining
  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_buttons_r <= in_button_levels;
      s1_dial_a_r  <= in_dial_a_level;
      s1_dial_b_r  <= in_dial_b_level;
    end
  end

  // one run counter per button; buttons beyond the sampled pins read high
  logic [BUTTON_COUNT-1:0] btn_pressed;

  for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_btn
    logic lvl;
    if (g < LEVEL_WIDTH) begin : g_pin
      assign lvl = s1_buttons_r[g];
    end else begin : g_idle
      assign lvl = 1'b1;
    end
    pbd_run_counter u_run (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (s1_move),
      .level      (lvl),
      .hold_ticks (button_hold_r),
      .pressed    (btn_pressed[g])
    );
  end

  // dial line counters
  logic pa;
  logic pb;

  pbd_run_counter u_run_a (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (s1_move),
    .level      (s1_dial_a_r),
    .hold_ticks (dial_hold_r),
    .pressed    (pa)
  );

  pbd_run_counter u_run_b (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (s1_move),
    .level      (s1_dial_b_r),
    .hold_ticks (dial_hold_r),
    .pressed    (pb)
  );

  dial_status_t dial;

  pbd_dial_tracker u_dial (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (s1_move),
    .pa     (pa),
    .pb     (pb),
    .status (dial)
  );

  // lowest-numbered pressed button wins, a finished turn with a direction overrides it
  cmd_t btn_cmd;
  cmd_t sel_cmd;
  cmd_t last_cmd_nxt;
  cmd_t out_command_nxt;

  always_comb begin
    btn_cmd = CMD_NONE;
    for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
      if (btn_pressed[i]) btn_cmd = cmd_t'(i + 1);
    end
  end

  always_comb begin
    sel_cmd = btn_cmd;
    if (dial.done) begin
      if (dial.direction == DIR_LEFT) begin
        sel_cmd = CMD_LEFT;
      end else if (dial.direction == DIR_RIGHT) begin
        sel_cmd = CMD_RIGHT;
      end
    end
    last_cmd_nxt    = last_cmd_r;
    out_command_nxt = CMD_NONE;
    // a turn in progress reports nothing and keeps the last command
    if (!dial.active && (sel_cmd != last_cmd_r)) begin
      last_cmd_nxt    = sel_cmd;
      out_command_nxt = sel_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_cmd_r  <= CMD_NONE;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
      last_cmd_r  <= last_cmd_nxt;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_command_r <= out_command_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_command = out_command_r;

  // a reported command is always the one remembered as last
  a_last_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_command_r != CMD_NONE)) |-> (last_cmd_r == out_command_r))
    else $error("reported command differs from remembered last command");

  // the remembered command only changes when a word moves into the output register
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_move |=> $stable(last_cmd_r))
    else $error("last command changed without a word advancing");

  // codes beyond dial right never appear
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_command_r <= CMD_RIGHT))
    else $error("command code out of range");

endmodule

// ===== verif/panel_button_and_dial_decoder_top_tb.sv =====
// testbench for the panel button and dial decoder: random and directed samples against a predictor
`timescale 1ns / 1ps

module panel_button_and_dial_decoder_top_tb;
  import pbd_pkg::*;

  // cycles in a row with no word moving on either channel before the run is called hung
  localparam int QUIET_LIMIT = 2000;
  // debounce lengths in generated traffic are capped so that huge thresholds stay cheap
  localparam int MAX_HOLD_LEN = 60;

  typedef struct packed {
    logic [LEVEL_WIDTH-1:0] levels;
    logic                   dial_a;
    logic                   dial_b;
  } panel_sample_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [LEVEL_WIDTH-1:0] in_button_levels = '1;
  logic                   in_dial_a_level = 1'b1;
  logic                   in_dial_b_level = 1'b1;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CMD_WIDTH-1:0]   out_command;

  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0]  paddr = '0;
  logic [DATA_WIDTH-1:0]  pwdata = '0;
  logic [DATA_WIDTH-1:0]  prdata;
  logic                   pready;

  panel_button_and_dial_decoder_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_button_levels (in_button_levels),
    .in_dial_a_level  (in_dial_a_level),
    .in_dial_b_level  (in_dial_b_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command      (out_command),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // decoder predictor: its own copy of the hold thresholds, run counters,
  // dial phase tracker and last reported command
  // ---------------------------------------------------------------------------
  hold_t  button_hold = HOLD_RESET;
  hold_t  dial_hold   = HOLD_RESET;
  run_t   button_runs [BUTTON_COUNT] = '{default: '0};
  run_t   dial_a_run = '0;
  run_t   dial_b_run = '0;
  phase_t dial_phase_now = PH_ZERO;
  dir_t   turn_dir = DIR_NONE;
  logic   turning = 1'b0;
  cmd_t   prev_cmd = CMD_NONE;

  // low-run counter: cleared by a high sample, otherwise counts up to the
  // threshold and never past full scale
  function automatic run_t advance_run(input run_t run, input logic level, input hold_t th);
    if (level)
      return '0;
    if (run < th && run != {RUN_WIDTH{1'b1}})
      return run + 1'b1;
    return run;
  endfunction

  // one tick of the panel: returns the command word the block should emit
  function automatic cmd_t decode_sample(input logic [LEVEL_WIDTH-1:0] levels,
                                         input logic a_level, input logic b_level);
    cmd_t pick;
    logic pa;
    logic pb;
    logic finished;
    pick = CMD_NONE;
    finished = 1'b0;
    // lowest-numbered pressed button has priority
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      button_runs[i] = advance_run(button_runs[i], levels[i], button_hold);
      if (button_runs[i] >= button_hold && pick == CMD_NONE)
        pick = cmd_t'(i + 1);
    end
    dial_a_run = advance_run(dial_a_run, a_level, dial_hold);
    dial_b_run = advance_run(dial_b_run, b_level, dial_hold);
    pa = (dial_a_run >= dial_hold);
    pb = (dial_b_run >= dial_hold);
    // a new turn starts from a clean phase and no direction
    if (!turning && (pa || pb)) begin
      turning = 1'b1;
      dial_phase_now = PH_ZERO;
      turn_dir = DIR_NONE;
    end
    if (turning) begin
      if (dial_phase_now == PH_POS2 && !pa) turn_dir = DIR_RIGHT;
      if (dial_phase_now == PH_NEG2 && !pb) turn_dir = DIR_LEFT;
      if (pa && !pb) dial_phase_now = PH_POS1;
      if (!pa && pb) dial_phase_now = PH_NEG1;
      if (dial_phase_now == PH_POS1 && pb) dial_phase_now = PH_POS2;
      if (dial_phase_now == PH_NEG1 && pa) dial_phase_now = PH_NEG2;
      if (!pa && !pb) begin
        turning = 1'b0;
        finished = 1'b1;
      end
    end
    // mid-turn ticks report nothing and leave the last command alone
    if (turning)
      return CMD_NONE;
    // a finished turn with a direction overrides any button
    if (finished) begin
      if (turn_dir == DIR_LEFT)
        pick = CMD_LEFT;
      else if (turn_dir == DIR_RIGHT)
        pick = CMD_RIGHT;
    end
    // only changes of command are reported
    if (pick != prev_cmd) begin
      prev_cmd = pick;
      return pick;
    end
    return CMD_NONE;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus store, expected commands and run statistics
  // ---------------------------------------------------------------------------
  panel_sample_t pending_samples [$];
  panel_sample_t next_sample;
  cmd_t          expected_cmds [$];
  cmd_t          want_cmd;

  int sender_idle_pct = 0;
  int recv_idle_pct   = 0;
  int quiet_cycles    = 0;
  int samples_sent    = 0;
  int words_checked   = 0;
  int button_cmds     = 0;
  int dial_cmds       = 0;
  int mismatches      = 0;
  int settings_used   = 1;

  // ---------------------------------------------------------------------------
  // driver: presents queued samples, idles at random, holds a stalled word,
  // and predicts the command for each word the block takes
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_cmds.push_back(decode_sample(in_button_levels, in_dial_a_level,
                                              in_dial_b_level));
        samples_sent++;
      end
      // a stalled word stays on the bus untouched
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          next_sample = pending_samples.pop_front();
          in_valid <= 1'b1;
          in_button_levels <= next_sample.levels;
          in_dial_a_level <= next_sample.dial_a;
          in_dial_b_level <= next_sample.dial_b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random output stall, compare each command word with the oldest
  // prediction, and a watchdog on cycles with no traffic
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: command word %0h with nothing expected", out_command);
        end else begin
          want_cmd = expected_cmds.pop_front();
          words_checked++;
          if (out_command !== want_cmd) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: word %0d command expected %0d got %0h",
                       words_checked, want_cmd, out_command);
          end else if (want_cmd == CMD_LEFT || want_cmd == CMD_RIGHT) begin
            dial_cmds++;
          end else if (want_cmd != CMD_NONE) begin
            button_cmds++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no traffic for %0d cycles, %0d commands outstanding",
                 quiet_cycles, expected_cmds.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_samples(input logic [LEVEL_WIDTH-1:0] levels, input logic a_level,
                               input logic b_level, input int count);
    panel_sample_t s;
    s.levels = levels;
    s.dial_a = a_level;
    s.dial_b = b_level;
    repeat (count) pending_samples.push_back(s);
  endtask

  // register write over the apb port: setup cycle, then access until pready
  task automatic write_hold(input logic reg_idx, input hold_t value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= DATA_WIDTH'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == REG_BUTTON_HOLD)
      button_hold = value;
    else
      dial_hold = value;
  endtask

  task automatic set_thresholds(input hold_t btn_th, input hold_t dial_th);
    write_hold(REG_BUTTON_HOLD, btn_th);
    write_hold(REG_DIAL_HOLD, dial_th);
    settings_used++;
  endtask

  // sender holds off until every predicted command has come back
  task automatic settle();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_cmds.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // random panel traffic: held button patterns, some long enough to debounce,
  // mostly well-formed dial turns (some cut short or reversed), noise and idle gaps
  task automatic queue_traffic(input int count);
    int added;
    int kind;
    int blen;
    int dlen;
    int k;
    logic [LEVEL_WIDTH-1:0] lv;
    logic [1:0] ab;
    logic go_left;
    logic broken;
    blen = (button_hold < 1) ? 1 : (button_hold > MAX_HOLD_LEN) ? MAX_HOLD_LEN : button_hold;
    dlen = (dial_hold < 1) ? 1 : (dial_hold > MAX_HOLD_LEN) ? MAX_HOLD_LEN : dial_hold;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        // one button low, or any mix of buttons
        if ($urandom_range(0, 1))
          lv = ~(LEVEL_WIDTH'(1) << $urandom_range(0, LEVEL_WIDTH - 1));
        else
          lv = LEVEL_WIDTH'($urandom);
        k = $urandom_range(1, blen + 3);
        queue_samples(lv, 1'b1, 1'b1, k);
        added += k;
      end else if (kind <= 6) begin
        // quadrature turn, {a,b}: right 01 00 10 11, left 10 00 01 11
        go_left = $urandom_range(0, 1);
        broken = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) == 0)
          lv = ~(LEVEL_WIDTH'(1) << $urandom_range(0, LEVEL_WIDTH - 1));
        else
          lv = '1;
        for (int j = 0; j < 4; j++) begin
          case (j)
            0: ab = go_left ? 2'b10 : 2'b01;
            1: ab = 2'b00;
            2: ab = go_left ? 2'b01 : 2'b10;
            default: ab = 2'b11;
          endcase
          k = dlen + $urandom_range(0, 2);
          if (broken && $urandom_range(0, 2) == 0)
            k = $urandom_range(1, dlen);
          // broken turn backs out the way it came
          if (broken && j == 2 && $urandom_range(0, 1))
            ab = go_left ? 2'b10 : 2'b01;
          queue_samples(lv, ab[1], ab[0], k);
          added += k;
        end
      end else if (kind <= 8) begin
        k = $urandom_range(1, 8);
        for (int j = 0; j < k; j++)
          queue_samples(LEVEL_WIDTH'($urandom), 1'($urandom), 1'($urandom), 1);
        added += k;
      end else begin
        k = $urandom_range(1, dlen + 2);
        queue_samples('1, 1'b1, 1'b1, k);
        added += k;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // light sender idling, heavy output stall
    sender_idle_pct = 22;
    recv_idle_pct = 57;

    // reset thresholds before any register write
    queue_traffic(300);
    settle();

    // directed: every button alone, all low, repeats, both turn directions,
    // a turn overriding a button, a turn that never finishes, a reversal
    set_thresholds(1, 1);
    queue_samples(6'h3F, 1'b1, 1'b1, 1);
    queue_samples(6'h3E, 1'b1, 1'b1, 2);
    queue_samples(6'h3D, 1'b1, 1'b1, 1);
    queue_samples(6'h3B, 1'b1, 1'b1, 1);
    queue_samples(6'h37, 1'b1, 1'b1, 1);
    queue_samples(6'h2F, 1'b1, 1'b1, 1);
    queue_samples(6'h1F, 1'b1, 1'b1, 1);
    queue_samples(6'h00, 1'b1, 1'b1, 1);
    queue_samples(6'h3F, 1'b1, 1'b1, 1);
    queue_samples(6'h3F, 1'b0, 1'b1, 1);
    queue_samples(6'h3F, 1'b0, 1'b0, 1);
    queue_samples(6'h3F, 1'b1, 1'b0, 1);
    queue_samples(6'h3F, 1'b1, 1'b1, 1);
    queue_samples(6'h3E, 1'b1, 1'b0, 1);
    queue_samples(6'h3E, 1'b0, 1'b0, 1);
    queue_samples(6'h3E, 1'b0, 1'b1, 1);
    queue_samples(6'h3E, 1'b1, 1'b1, 1);
    queue_samples(6'h3F, 1'b0, 1'b1, 1);
    queue_samples(6'h3F, 1'b1, 1'b1, 1);
    queue_samples(6'h3F, 1'b0, 1'b0, 1);
    queue_samples(6'h3F, 1'b0, 1'b1, 1);
    queue_samples(6'h1F, 1'b1, 1'b1, 2);
    settle();

    set_thresholds(3, 2);
    queue_traffic(500);
    settle();

    // heavy sender idling, light output stall
    sender_idle_pct = 57;
    recv_idle_pct = 22;

    // zero threshold: every line counts as pressed at once
    set_thresholds(0, 0);
    queue_traffic(60);
    settle();

    set_thresholds(1, 4);
    queue_traffic(450);
    settle();

    // full-scale thresholds: nothing can ever be pressed in this run
    set_thresholds(16'hFFFF, 16'hFFFF);
    queue_traffic(60);
    settle();

    // back to back, no idling on either side
    sender_idle_pct = 0;
    recv_idle_pct = 0;
    set_thresholds(2, 1);
    queue_traffic(500);
    settle();

    // anything late shows up as an extra word
    repeat (20) @(posedge clk);

    $display("sent %0d samples over %0d threshold settings, checked %0d command words",
             samples_sent, settings_used, words_checked);
    $display("%0d button and %0d dial commands reported, %0d mismatches",
             button_cmds, dial_cmds, mismatches);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
